// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property, checked during reset too.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/lse_pkg.sv =====
package lse_pkg;

  localparam logic [7:0] MAGIC_CHAR_RST   = 8'd35;
  localparam logic [7:0] HEADER_BYTES_RST = 8'd54;
  localparam int unsigned MAX_EXT_LEN_DEF = 4;

  // Configuration register indexes
  localparam logic CFG_MAGIC_CHAR   = 1'b0;
  localparam logic CFG_HEADER_BYTES = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_MAGIC    = 3'd1,
    PH_EXT_LEN  = 3'd2,
    PH_EXT_DATA = 3'd3,
    PH_SIZE     = 3'd4,
    PH_PAYLOAD  = 3'd5,
    PH_HALT     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_EXT     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_EXT_LONG  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    status_t    status;
    logic       last;
  } result_t;

endpackage

// ===== rtl/lsb_stego_extractor.sv =====
// LSB steganography extractor. Feed the bytes of a stego bitmap file, one
// item per cycle, with in_start_of_file high on the first byte of each file
// (the block also starts fresh out of reset). The first header_bytes bytes
// are skipped; from then on bit 0 of each byte is shifted in, most
// significant bit first, to form an 8-bit magic character (checked against
// magic_char), a 32-bit extension length, that many extension characters, a
// 32-bit payload size and the payload bytes. Every extension character and
// payload byte comes out as one result item; the last payload byte has
// out_last set. A magic mismatch, an extension length above MAX_EXT_LEN or
// a zero payload size gives one status item (out_kind status, out_last set)
// and the block then drops all bytes until the next start of file. Each
// input byte is decoded in the cycle it is accepted and its result lands in
// a two-entry output buffer, so the block sustains one item per cycle;
// in_stall rises only when both buffer entries hold results the consumer
// has not taken. Write configuration only while the block is idle.
module lsb_stego_extractor
  import lse_pkg::*;
#(
  parameter int unsigned MAX_EXT_LEN = MAX_EXT_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // image byte stream
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_image_byte,
  input  logic       in_start_of_file,
  // decoded items
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic [1:0] out_kind,
  output logic [1:0] out_status,
  output logic       out_last
);

  localparam int unsigned EXT_W = $clog2(MAX_EXT_LEN + 1);

  // configuration registers
  logic [7:0] magic_char_r;
  logic [7:0] header_bytes_r;

  // decoder state
  phase_t           phase_r,       phase_nxt;
  logic [7:0]       count_r,       count_nxt;
  logic [31:0]      shift_r,       shift_nxt;
  logic [4:0]       bit_cnt_r,     bit_cnt_nxt;
  logic [EXT_W-1:0] ext_rem_r,     ext_rem_nxt;
  logic [31:0]      pay_rem_r,     pay_rem_nxt;

  // output buffer: head drives the ports, skid catches one more
  result_t head_r, skid_r;
  logic    head_valid_r, skid_valid_r;

  phase_t      phase_eff;
  phase_t      field_phase;
  logic [7:0]  count_eff;
  logic [31:0] shift_eff;
  logic [31:0] shift_new;
  logic [4:0]  bit_cnt_eff;
  logic        field_done;
  logic        res_valid;
  result_t     res;
  logic        in_accept;
  logic        out_pop;
  logic        push;

  assign in_accept = in_valid & ~in_stall;
  assign out_pop   = head_valid_r & ~out_stall;
  assign push      = in_accept & res_valid;
  assign in_stall  = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_char_r   <= MAGIC_CHAR_RST;
      header_bytes_r <= HEADER_BYTES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAGIC_CHAR:   magic_char_r   <= cfg_data;
        CFG_HEADER_BYTES: header_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode one byte: a start of file first clears the state it sees.
  always_comb begin
    phase_eff   = in_start_of_file ? PH_HEADER : phase_r;
    count_eff   = in_start_of_file ? 8'd0 : count_r;
    shift_eff   = in_start_of_file ? 32'd0 : shift_r;
    bit_cnt_eff = in_start_of_file ? 5'd0 : bit_cnt_r;

    phase_nxt   = phase_eff;
    count_nxt   = count_eff;
    shift_nxt   = shift_eff;
    bit_cnt_nxt = bit_cnt_eff;
    ext_rem_nxt = ext_rem_r;
    pay_rem_nxt = pay_rem_r;

    res_valid  = 1'b0;
    res.ch     = 8'd0;
    res.kind   = KIND_STATUS;
    res.status = ST_OK;
    res.last   = 1'b0;

    field_phase = (phase_eff == PH_HEADER) ? PH_MAGIC : phase_eff;
    shift_new   = {shift_eff[30:0], in_image_byte[0]};
    field_done  = ((field_phase == PH_EXT_LEN) || (field_phase == PH_SIZE)) ?
                  (bit_cnt_eff == 5'd31) : (bit_cnt_eff == 5'd7);

    priority if (phase_eff == PH_HALT) begin
      // drop bytes until the next start of file
    end else if (phase_eff == PH_HEADER && count_eff < header_bytes_r) begin
      count_nxt = count_eff + 8'd1;
    end else if (!field_done) begin
      phase_nxt   = field_phase;
      shift_nxt   = shift_new;
      bit_cnt_nxt = bit_cnt_eff + 5'd1;
    end else begin
      shift_nxt   = 32'd0;
      bit_cnt_nxt = 5'd0;
      unique case (field_phase)
        PH_MAGIC: begin
          if (shift_new[7:0] != magic_char_r) begin
            phase_nxt  = PH_HALT;
            res_valid  = 1'b1;
            res.status = ST_BAD_MAGIC;
            res.last   = 1'b1;
          end else begin
            phase_nxt = PH_EXT_LEN;
          end
        end
        PH_EXT_LEN: begin
          if (shift_new > 32'(MAX_EXT_LEN)) begin
            phase_nxt  = PH_HALT;
            res_valid  = 1'b1;
            res.status = ST_EXT_LONG;
            res.last   = 1'b1;
          end else begin
            ext_rem_nxt = shift_new[EXT_W-1:0];
            phase_nxt   = (shift_new == 32'd0) ? PH_SIZE : PH_EXT_DATA;
          end
        end
        PH_EXT_DATA: begin
          ext_rem_nxt = ext_rem_r - EXT_W'(1);
          if (ext_rem_r == EXT_W'(1)) phase_nxt = PH_SIZE;
          res_valid = 1'b1;
          res.ch    = shift_new[7:0];
          res.kind  = KIND_EXT;
        end
        PH_SIZE: begin
          if (shift_new == 32'd0) begin
            phase_nxt  = PH_HALT;
            res_valid  = 1'b1;
            res.status = ST_EMPTY;
            res.last   = 1'b1;
          end else begin
            pay_rem_nxt = shift_new;
            phase_nxt   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          pay_rem_nxt = pay_rem_r - 32'd1;
          res_valid   = 1'b1;
          res.ch      = shift_new[7:0];
          res.kind    = KIND_PAYLOAD;
          if (pay_rem_r == 32'd1) begin
            phase_nxt = PH_HALT;
            res.last  = 1'b1;
          end
        end
        default: phase_nxt = PH_HALT;
      endcase
    end
  end

  // Advance the decoder state only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      count_r   <= 8'd0;
      shift_r   <= 32'd0;
      bit_cnt_r <= 5'd0;
      ext_rem_r <= '0;
      pay_rem_r <= 32'd0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      shift_r   <= shift_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      ext_rem_r <= ext_rem_nxt;
      pay_rem_r <= pay_rem_nxt;
    end
  end

  // Output buffer valid bits: refill the head from the skid first, so
  // order is kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!head_valid_r || out_pop) begin
      head_valid_r <= skid_valid_r | push;
      skid_valid_r <= skid_valid_r & push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload of the buffer: no reset needed.
  always_ff @(posedge clk) begin
    if (!head_valid_r || out_pop) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
        if (push) skid_r <= res;
      end else if (push) begin
        head_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid  = head_valid_r;
  assign out_char   = head_r.ch;
  assign out_kind   = head_r.kind;
  assign out_status = head_r.status;
  assign out_last   = head_r.last;

endmodule

// ===== rtl/lse_checker.sv =====
`include "assert_macros.svh"

module lse_checker
  import lse_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic [1:0] out_kind,
  input logic [1:0] out_status,
  input logic       out_last
);

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_kind) && $stable(out_status) && $stable(out_last), "stalled output item changed")

  `ASSERT_CLK(a_status_form, out_valid && out_kind == KIND_STATUS |-> out_char == 8'd0 && out_last && out_status != ST_OK, "malformed status item")

  `ASSERT_CLK(a_data_ok, out_valid && out_kind != KIND_STATUS |-> out_status == ST_OK && (out_kind == KIND_EXT || out_kind == KIND_PAYLOAD), "data item with bad kind or status")

  `ASSERT_CLK(a_ext_not_last, out_valid && out_kind == KIND_EXT |-> !out_last, "extension character marked last")

  `ASSERT_CLK_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind lsb_stego_extractor lse_checker u_lse_checker (.*);

// ===== tb/sv/tb_lsb_stego_extractor.sv =====
`timescale 1ns / 100ps

module tb_lsb_stego_extractor;
  import lse_pkg::*;

  localparam int unsigned MAX_EXT = MAX_EXT_LEN_DEF;

  // Clock, reset and all block inputs start at known values.
  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = CFG_MAGIC_CHAR;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_image_byte = 8'd0;
  logic       in_start_of_file = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic [1:0] out_kind;
  logic [1:0] out_status;
  logic       out_last;

  lsb_stego_extractor u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_image_byte    (in_image_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  // Decoder state mirrored on the testbench side, plus copies of the registers.
  phase_t      dec_phase = PH_HEADER;
  logic [7:0]  skip_count = 8'd0;
  logic [31:0] bit_acc = 32'd0;
  logic [5:0]  bits_held = 6'd0;
  logic [31:0] ext_left = 32'd0;
  logic [31:0] payload_left = 32'd0;
  logic [7:0]  magic_reg = MAGIC_CHAR_RST;
  logic [7:0]  header_reg = HEADER_BYTES_RST;

  result_t     expected_chars[$];   // decoded items still owed by the block
  result_t     oldest_char;
  logic [7:0]  char_pool[$];        // fixed characters for directed files
  logic        sof_next = 1'b0;     // mark the next byte as start of file
  logic        idle_in = 1'b1;
  logic        idle_out = 1'b1;
  logic        out_take = 1'b0;
  int unsigned stall_cycles;
  int unsigned bytes_sent = 0;
  int unsigned mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic push_expected(input logic [7:0] ch, input kind_t kind,
                               input status_t status, input logic last);
    result_t r;
    r.ch = ch;
    r.kind = kind;
    r.status = status;
    r.last = last;
    expected_chars.push_back(r);
  endtask

  // Advance the mirrored decoder by one accepted byte and queue any result it owes.
  task automatic predict_decode(input logic [7:0] b, input logic sof);
    logic [31:0] field;
    int unsigned need;
    if (sof) begin
      dec_phase = PH_HEADER;
      skip_count = 8'd0;
      bit_acc = 32'd0;
      bits_held = 6'd0;
      ext_left = 32'd0;
      payload_left = 32'd0;
    end
    if (dec_phase == PH_HALT)
      return;
    if (dec_phase == PH_HEADER) begin
      if (skip_count < header_reg) begin
        skip_count = skip_count + 8'd1;
        return;
      end
      dec_phase = PH_MAGIC;
    end
    bit_acc = {bit_acc[30:0], b[0]};
    bits_held = bits_held + 6'd1;
    need = (dec_phase == PH_EXT_LEN || dec_phase == PH_SIZE) ? 32 : 8;
    if (bits_held < need)
      return;
    field = (need == 8) ? {24'd0, bit_acc[7:0]} : bit_acc;
    bit_acc = 32'd0;
    bits_held = 6'd0;
    case (dec_phase)
      PH_MAGIC: begin
        if (field[7:0] != magic_reg) begin
          dec_phase = PH_HALT;
          push_expected(8'd0, KIND_STATUS, ST_BAD_MAGIC, 1'b1);
        end else begin
          dec_phase = PH_EXT_LEN;
        end
      end
      PH_EXT_LEN: begin
        if (field > MAX_EXT) begin
          dec_phase = PH_HALT;
          push_expected(8'd0, KIND_STATUS, ST_EXT_LONG, 1'b1);
        end else begin
          ext_left = field;
          dec_phase = (field == 0) ? PH_SIZE : PH_EXT_DATA;
        end
      end
      PH_EXT_DATA: begin
        ext_left = ext_left - 32'd1;
        if (ext_left == 0)
          dec_phase = PH_SIZE;
        push_expected(field[7:0], KIND_EXT, ST_OK, 1'b0);
      end
      PH_SIZE: begin
        if (field == 0) begin
          dec_phase = PH_HALT;
          push_expected(8'd0, KIND_STATUS, ST_EMPTY, 1'b1);
        end else begin
          payload_left = field;
          dec_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        payload_left = payload_left - 32'd1;
        if (payload_left == 0) begin
          dec_phase = PH_HALT;
          push_expected(field[7:0], KIND_PAYLOAD, ST_OK, 1'b1);
        end else begin
          push_expected(field[7:0], KIND_PAYLOAD, ST_OK, 1'b0);
        end
      end
      default: dec_phase = PH_HALT;
    endcase
  endtask

  // Send one image byte. Call right after a rising edge; return right after
  // the edge that accepted the item, with valid still high.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    logic        sof;
    logic        taken;
    sof = sof_next;
    sof_next = 1'b0;
    gap = idle_in ? $urandom_range(16, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_image_byte <= b;
    in_start_of_file <= sof;
    // in_stall settles by the falling edge; it then holds to the next rising edge.
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    predict_decode(b, sof);
    bytes_sent++;
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // Hide a field in bit 0 of consecutive bytes, most significant bit first.
  task automatic send_field(input logic [31:0] v, input int nbits);
    logic [7:0] b;
    for (int i = nbits - 1; i >= 0; i--) begin
      b = 8'($urandom);
      b[0] = v[i];
      send_byte(b);
    end
  endtask

  task automatic send_char();
    if (char_pool.size() != 0)
      send_field({24'd0, char_pool.pop_front()}, 8);
    else
      send_field($urandom, 8);
  endtask

  task automatic send_file(input int unsigned hdr, input logic [7:0] magic,
                           input logic [31:0] ext_len, input int unsigned n_ext,
                           input logic [31:0] size, input int unsigned n_pay,
                           input logic with_sof);
    sof_next = with_sof;
    send_noise(hdr);
    send_field({24'd0, magic}, 8);
    send_field(ext_len, 32);
    repeat (n_ext) send_char();
    send_field(size, 32);
    repeat (n_pay) send_char();
  endtask

  // Drop valid and hold until every owed item is out and the block is quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pulse the write enable for one edge, then drop it and update the register copy.
  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MAGIC_CHAR)
      magic_reg = data;
    else
      header_reg = data;
  endtask

  // Result side: hold stall for a random number of cycles before each item.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      stall_cycles = idle_out ? $urandom_range(16, 0) : 0;
      if (stall_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_take);
    end
  end

  // Sample at the falling edge: an item seen here is taken at the next rising edge.
  always @(negedge clk) begin
    out_take = rst_n && out_valid && !out_stall;
    if (out_take) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("item with nothing expected", {24'd0, out_char}, 32'd0);
      end else begin
        oldest_char = expected_chars.pop_front();
        if (out_char !== oldest_char.ch)
          report_mismatch("out_char", {24'd0, out_char}, {24'd0, oldest_char.ch});
        if (out_kind !== oldest_char.kind)
          report_mismatch("out_kind", {30'd0, out_kind}, {30'd0, oldest_char.kind});
        if (out_status !== oldest_char.status)
          report_mismatch("out_status", {30'd0, out_status}, {30'd0, oldest_char.status});
        if (out_last !== oldest_char.last)
          report_mismatch("out_last", {31'd0, out_last}, {31'd0, oldest_char.last});
      end
    end
  end

  // Out of reset with no start mark: decode with the reset register values.
  task automatic test_reset_defaults();
    char_pool = '{8'h00, 8'hFF};
    send_file(32'(HEADER_BYTES_RST), MAGIC_CHAR_RST, 1, 1, 1, 1, 1'b0);
  endtask

  // Zero header: the start-of-file byte carries the first hidden bit. Also an
  // empty extension and the all-ones magic.
  task automatic test_zero_header();
    wait_idle();
    write_reg(CFG_MAGIC_CHAR, 8'hFF);
    write_reg(CFG_HEADER_BYTES, 8'd0);
    char_pool = '{8'h00};
    send_file(0, 8'hFF, 0, 0, 1, 1, 1'b1);
  endtask

  // Longest legal extension, then trailing bytes after the last payload byte.
  task automatic test_max_extension();
    wait_idle();
    write_reg(CFG_MAGIC_CHAR, 8'h00);
    write_reg(CFG_HEADER_BYTES, 8'd3);
    char_pool = '{8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
    send_file(3, 8'h00, MAX_EXT, MAX_EXT, 2, 2, 1'b1);
    send_noise(12);
  endtask

  // Magic mismatch halts; a whole well-formed file without a start mark is dropped.
  task automatic test_bad_magic();
    send_file(3, 8'h01, 0, 0, 1, 1, 1'b1);
    send_file(3, 8'h00, 1, 1, 1, 1, 1'b0);
  endtask

  // Extension length just over the limit, then the largest possible length.
  task automatic test_ext_too_long();
    send_file(3, 8'h00, MAX_EXT + 1, 0, 1, 0, 1'b1);
    send_file(3, 8'h00, 32'hFFFF_FFFF, 0, 1, 0, 1'b1);
  endtask

  task automatic test_empty_payload();
    send_file(3, 8'h00, 1, 1, 0, 0, 1'b1);
    send_noise(8);
  endtask

  // Start of file in the middle of the extension length restarts cleanly.
  task automatic test_restart_mid_file();
    sof_next = 1'b1;
    send_noise(3);
    send_field(32'h0, 8);
    send_field(32'h1FFF, 13);
    send_file(3, 8'h00, 2, 2, 3, 3, 1'b1);
  endtask

  // Largest header skip.
  task automatic test_large_header();
    wait_idle();
    write_reg(CFG_HEADER_BYTES, 8'hFF);
    write_reg(CFG_MAGIC_CHAR, 8'h5C);
    send_file(255, 8'h5C, 1, 1, 1, 1, 1'b1);
  endtask

  // Mostly well-formed files with random content; the rest broken or noise.
  task automatic test_random_files();
    int unsigned start_bytes;
    int unsigned pick;
    int unsigned ext_n;
    int unsigned pay_n;
    logic [31:0] len;
    logic [7:0]  mg;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 400) begin
      idle_in = $urandom_range(3, 0) != 0;
      idle_out = $urandom_range(3, 0) != 0;
      if ($urandom_range(7, 0) == 0) begin
        wait_idle();
        pick = $urandom_range(3, 0);
        mg = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        write_reg(CFG_MAGIC_CHAR, mg);
        write_reg(CFG_HEADER_BYTES,
                  ($urandom_range(15, 0) == 0) ? 8'hFF : 8'($urandom_range(10, 0)));
      end
      pick = $urandom_range(99, 0);
      ext_n = $urandom_range(MAX_EXT, 0);
      pay_n = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1);
      if (pick < 60) begin
        send_file(32'(header_reg), magic_reg, ext_n, ext_n, pay_n, pay_n, 1'b1);
        if ($urandom_range(3, 0) == 0)
          send_noise($urandom_range(10, 1));
      end else if (pick < 68) begin
        mg = magic_reg ^ 8'($urandom_range(255, 1));
        sof_next = 1'b1;
        send_noise(32'(header_reg));
        send_field({24'd0, mg}, 8);
        send_noise($urandom_range(8, 0));
      end else if (pick < 76) begin
        if ($urandom_range(1, 0) == 0)
          len = 32'($urandom_range(20, MAX_EXT + 1));
        else
          len = $urandom | (32'h1 << $urandom_range(31, 3));
        send_file(32'(header_reg), magic_reg, len, 0, 1, 0, 1'b1);
      end else if (pick < 84) begin
        send_file(32'(header_reg), magic_reg, ext_n, ext_n, 0, 0, 1'b1);
        send_noise($urandom_range(8, 0));
      end else if (pick < 92) begin
        // huge size: the file is cut off before its payload ends
        send_file(32'(header_reg), magic_reg, ext_n, ext_n, $urandom | 32'h100,
                  $urandom_range(4, 0), 1'b1);
      end else begin
        sof_next = 1'($urandom_range(1, 0));
        send_noise($urandom_range(40, 1));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_header();
    test_max_extension();
    test_bad_magic();
    test_ext_too_long();
    test_empty_payload();
    test_restart_mid_file();
    test_large_header();
    test_random_files();
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
